// File: hw/rtl/fdfs_pkg.sv
// shared types and constants of the fixed delimiter field splitter
package fdfs_pkg;

    localparam int DELIM_MAX   = 8;
    localparam int DELIM_IDX_W = $clog2(DELIM_MAX);
    localparam int DLEN_W      = 4;
    localparam int OFF_W       = 16;
    localparam int CNT_W       = OFF_W + 1;
    localparam int LIMIT_W     = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;

    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES  = 3'd0,
        CFG_DELIM_LENGTH = 3'd1,
        CFG_FIELD_LIMIT  = 3'd2,
        CFG_LIMIT_EN     = 3'd3,
        CFG_OMIT_EMPTY   = 3'd4,
        CFG_TOKENS_ONLY  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [8*DELIM_MAX-1:0] delim_bytes;
        logic [DLEN_W-1:0]      delim_len;
        logic [LIMIT_W-1:0]     field_limit;
        logic                   limit_en;
        logic                   skip_empty;
        logic                   tokens_mode;
    } cfg_t;

    typedef struct packed {
        logic [OFF_W-1:0] field_start;
        logic [OFF_W-1:0] field_end;
        logic             last_field;
        logic             no_fields;
        logic             overflow;
    } result_t;

    // results produced by one transaction, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// File: hw/rtl/fdfs_stream_if.sv
// stream interfaces for the byte input and the field output
interface fdfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_string, input ready);
    modport sink (input valid, input data_byte, input has_byte,
                  input end_of_string, output ready);
endinterface

interface fdfs_out_if;
    logic                         valid;
    logic                         ready;
    logic [fdfs_pkg::OFF_W-1:0]   field_start;
    logic [fdfs_pkg::OFF_W-1:0]   field_end;
    logic                         last_field;
    logic                         no_fields;
    logic                         overflow;

    modport source (output valid, output field_start, output field_end,
                    output last_field, output no_fields, output overflow, input ready);
    modport sink (input valid, input field_start, input field_end,
                  input last_field, input no_fields, input overflow, output ready);
endinterface

// File: hw/rtl/fdfs_match_cell.sv
// one window cell: holds a byte, compares it to its delimiter byte, passes the hit on
module fdfs_match_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [fdfs_pkg::DELIM_IDX_W-1:0]      cell_index,
    input  logic                                  shift,
    input  logic [7:0]                            byte_in,
    input  logic [8*fdfs_pkg::DELIM_MAX-1:0]      delim_bytes,
    input  logic [fdfs_pkg::DLEN_W-1:0]           delim_len,
    input  logic                                  hit_in,
    output logic [7:0]                            byte_out,
    output logic                                  hit_out
);

    logic [7:0]                       byte_reg;
    logic                             used;
    logic [fdfs_pkg::DELIM_IDX_W-1:0] sel;
    logic [7:0]                       delim_byte;

    // cell j sees the byte j places back, which must equal delimiter byte len-1-j
    assign used       = {{(fdfs_pkg::DLEN_W-fdfs_pkg::DELIM_IDX_W){1'b0}}, cell_index}
                        < delim_len;
    assign sel        = fdfs_pkg::DELIM_IDX_W'(delim_len - fdfs_pkg::DLEN_W'(1)
                        - fdfs_pkg::DLEN_W'(cell_index));
    assign delim_byte = delim_bytes[8*sel +: 8];
    assign hit_out    = hit_in & (~used | (byte_in == delim_byte));
    assign byte_out   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

// File: hw/rtl/fdfs_ctrl.sv
// field bookkeeping: positions, field counts, the held-back field and result forming
module fdfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fdfs_pkg::cfg_t        cfg,
    input  logic                  accept,
    input  logic                  has_byte,
    input  logic                  end_of_string,
    input  logic                  match,
    output fdfs_pkg::result_pair_t results
);

    localparam int OW = fdfs_pkg::OFF_W;
    localparam int CW = fdfs_pkg::CNT_W;

    logic [OW-1:0] pos_reg, pos_next;
    logic [OW-1:0] cfs_reg, cfs_next;
    logic [OW-1:0] ems_reg, ems_next;
    logic [CW-1:0] fo_reg, fo_next;
    logic          pv_reg, pv_next;
    logic [OW-1:0] pend_start_reg, pend_start_next;
    logic [OW-1:0] pend_end_reg, pend_end_next;
    logic          ovf_reg, ovf_next;
    logic          emitted_reg, emitted_next;

    fdfs_pkg::result_t res_next [2];
    logic [1:0]        push_n;

    always_comb
    begin
        logic [CW-1:0] p1;
        logic [CW-1:0] lim;
        logic [OW-1:0] nxt;
        logic [OW-1:0] s1;
        logic [OW-1:0] cs;
        logic [OW-1:0] fs;
        logic [OW-1:0] fe;
        logic          may;
        logic          keep;
        logic          ovf_now;

        pos_next        = pos_reg;
        cfs_next        = cfs_reg;
        ems_next        = ems_reg;
        fo_next         = fo_reg;
        pv_next         = pv_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        ovf_next        = ovf_reg;
        emitted_next    = emitted_reg;
        res_next[0]     = '0;
        res_next[1]     = '0;
        push_n          = 2'd0;

        p1      = {1'b0, pos_reg} + CW'(1);
        lim     = {1'b0, cfg.field_limit} + CW'(cfg.tokens_mode);
        nxt     = (pos_reg == fdfs_pkg::OFF_MAX) ? pos_reg : p1[OW-1:0];
        s1      = OW'(p1 - CW'(cfg.delim_len));
        cs      = cfs_reg;
        may     = ~cfg.limit_en | (fo_reg < lim);
        ovf_now = ovf_reg | (accept & has_byte & (pos_reg == fdfs_pkg::OFF_MAX));
        fs      = '0;
        fe      = '0;
        keep    = 1'b0;

        if (accept && has_byte)
        begin
            ovf_next = ovf_now;
            pos_next = nxt;
            if (cfg.delim_len != '0 && may && p1 >= CW'(cfg.delim_len) && match
                && s1 >= ems_reg)
            begin
                ems_next = nxt;
                if (cfg.skip_empty && cfs_reg == s1)
                begin
                    cfs_next = nxt;
                end
                else
                begin
                    cfs_next = nxt;
                    if (fo_reg != fdfs_pkg::CNT_MAX)
                    begin
                        fo_next = fo_reg + CW'(1);
                    end
                    if (pv_reg || cfg.skip_empty)
                    begin
                        if (pv_reg)
                        begin
                            res_next[push_n[0]] = '{pend_start_reg, pend_end_reg,
                                                    1'b0, 1'b0, ovf_now};
                            push_n = push_n + 2'd1;
                        end
                        pend_start_next = cs;
                        pend_end_next   = s1;
                        pv_next         = 1'b1;
                    end
                    else
                    begin
                        res_next[push_n[0]] = '{cs, s1,
                            cfg.limit_en & cfg.tokens_mode & (fo_next > {1'b0, cfg.field_limit}),
                            1'b0, ovf_now};
                        push_n = push_n + 2'd1;
                    end
                end
            end
        end

        if (accept && end_of_string)
        begin
            fs   = cfs_next;
            fe   = pos_next;
            keep = 1'b1;
            if (cfg.limit_en && cfg.field_limit == '0)
            begin
                keep = 1'b0;
            end
            if (cfg.limit_en && cfg.tokens_mode && fo_next > {1'b0, cfg.field_limit})
            begin
                keep = 1'b0;
            end
            if (fs == fe && (cfg.skip_empty || pv_next))
            begin
                keep = 1'b0;
            end
            if (pv_next)
            begin
                res_next[push_n[0]] = '{pend_start_next, pend_end_next, ~keep, 1'b0, ovf_now};
                push_n = push_n + 2'd1;
            end
            if (keep)
            begin
                res_next[push_n[0]] = '{fs, fe, 1'b1, 1'b0, ovf_now};
                push_n = push_n + 2'd1;
            end
            if (push_n == 2'd0 && !emitted_reg)
            begin
                res_next[0] = '{'0, '0, 1'b1, 1'b1, ovf_now};
                push_n      = 2'd1;
            end
            // string done: back to the reset state
            pos_next        = '0;
            cfs_next        = '0;
            ems_next        = '0;
            fo_next         = CW'(1);
            pv_next         = 1'b0;
            pend_start_next = '0;
            pend_end_next   = '0;
            ovf_next        = 1'b0;
            emitted_next    = 1'b0;
        end
        else if (push_n != 2'd0)
        begin
            emitted_next = 1'b1;
        end
    end

    assign results = '{push_n, res_next[0], res_next[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            cfs_reg        <= '0;
            ems_reg        <= '0;
            fo_reg         <= CW'(1);
            pv_reg         <= 1'b0;
            pend_start_reg <= '0;
            pend_end_reg   <= '0;
            ovf_reg        <= 1'b0;
            emitted_reg    <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            cfs_reg        <= cfs_next;
            ems_reg        <= ems_next;
            fo_reg         <= fo_next;
            pv_reg         <= pv_next;
            pend_start_reg <= pend_start_next;
            pend_end_reg   <= pend_end_next;
            ovf_reg        <= ovf_next;
            emitted_reg    <= emitted_next;
        end
    end

endmodule

// File: hw/rtl/fdfs_out_queue.sv
// small result queue: takes up to two results a cycle, gives one when out_ready is high
module fdfs_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fdfs_pkg::result_pair_t results,
    output logic                   space_for_two,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fdfs_pkg::result_t      out_data
);

    localparam int PW = fdfs_pkg::Q_PTR_W;
    localparam int NW = fdfs_pkg::Q_CNT_W;

    fdfs_pkg::result_t mem [fdfs_pkg::Q_DEPTH];

    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          pop;

    assign pop           = out_valid & out_ready;
    assign out_valid     = (count_reg != '0);
    assign out_data      = mem[rptr_reg];
    assign space_for_two = (count_reg <= NW'(fdfs_pkg::Q_DEPTH - 2));

    always_comb
    begin
        wptr_next  = wptr_reg + PW'(results.count);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + NW'(results.count) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (results.count != 2'd0)
        begin
            mem[wptr_reg] <= results.first;
        end
        if (results.count == 2'd2)
        begin
            mem[wptr_reg + PW'(1)] <= results.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/fixed_delimiter_field_splitter.sv
// top level of the fixed delimiter field splitter
//
//   channel        direction  carries
//   byte_stream    in         data_byte, has_byte, end_of_string
//   field_stream   out        field_start, field_end, last_field, no_fields, overflow
//   cfg_*          in         register writes, index and 64-bit data
//
// one byte transaction per cycle while ready is high; the delimiter compare runs
// across the row of eight window cells in the same cycle as the byte arrives
// a transaction gives up to two results, drained from a four-entry queue one per cycle
// when the output is ready; byte_stream.ready is low while three or more results wait
// asynchronous reset returns the registers and string state to reset; no clearing pass
module fixed_delimiter_field_splitter (
    input  logic                              clk,
    input  logic                              rst_n,
    fdfs_in_if.sink                           byte_stream,
    fdfs_out_if.source                        field_stream,
    input  logic                              cfg_write,
    input  logic [fdfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int N = fdfs_pkg::DELIM_MAX;

    fdfs_pkg::cfg_t         cfg_reg, cfg_next;
    fdfs_pkg::result_pair_t results;
    fdfs_pkg::result_t      out_data;

    logic             accept;
    logic             space_for_two;
    logic             shift;
    logic [7:0]       chain_byte [N+1];
    logic             chain_hit  [N+1];

    assign byte_stream.ready = space_for_two;
    assign accept            = byte_stream.valid & space_for_two;
    assign shift             = accept & byte_stream.has_byte;

    // register writes; the length is clamped on the way in
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (fdfs_pkg::cfg_index_t'(cfg_index))
                fdfs_pkg::CFG_DELIM_BYTES:  cfg_next.delim_bytes = cfg_data;
                fdfs_pkg::CFG_DELIM_LENGTH:
                begin
                    cfg_next.delim_len = (cfg_data[fdfs_pkg::DLEN_W-1:0] > fdfs_pkg::DLEN_W'(N))
                                         ? fdfs_pkg::DLEN_W'(N)
                                         : cfg_data[fdfs_pkg::DLEN_W-1:0];
                end
                fdfs_pkg::CFG_FIELD_LIMIT:  cfg_next.field_limit = cfg_data[fdfs_pkg::LIMIT_W-1:0];
                fdfs_pkg::CFG_LIMIT_EN:     cfg_next.limit_en    = cfg_data[0];
                fdfs_pkg::CFG_OMIT_EMPTY:   cfg_next.skip_empty  = cfg_data[0];
                fdfs_pkg::CFG_TOKENS_ONLY:  cfg_next.tokens_mode = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{delim_len: fdfs_pkg::DLEN_W'(1), default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign chain_byte[0] = byte_stream.data_byte;
    assign chain_hit[0]  = 1'b1;

    for (genvar j = 0; j < N; j++)
    begin : g_cell
        fdfs_match_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_index  (fdfs_pkg::DELIM_IDX_W'(j)),
            .shift       (shift),
            .byte_in     (chain_byte[j]),
            .delim_bytes (cfg_reg.delim_bytes),
            .delim_len   (cfg_reg.delim_len),
            .hit_in      (chain_hit[j]),
            .byte_out    (chain_byte[j+1]),
            .hit_out     (chain_hit[j+1])
        );
    end

    fdfs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .has_byte      (byte_stream.has_byte),
        .end_of_string (byte_stream.end_of_string),
        .match         (chain_hit[N]),
        .results       (results)
    );

    fdfs_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .results       (results),
        .space_for_two (space_for_two),
        .out_valid     (field_stream.valid),
        .out_ready     (field_stream.ready),
        .out_data      (out_data)
    );

    assign field_stream.field_start = out_data.field_start;
    assign field_stream.field_end   = out_data.field_end;
    assign field_stream.last_field  = out_data.last_field;
    assign field_stream.no_fields   = out_data.no_fields;
    assign field_stream.overflow    = out_data.overflow;

endmodule

// File: hw/rtl/fdfs_checker.sv
// port-level checks on the field output, bound to the top level
module fdfs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  logic                          ready,
    input  logic [fdfs_pkg::OFF_W-1:0]    field_start,
    input  logic [fdfs_pkg::OFF_W-1:0]    field_end,
    input  logic                          last_field,
    input  logic                          no_fields,
    input  logic                          overflow
);

    // a stalled transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("field output dropped while stalled");

    // and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable({field_start, field_end, last_field, no_fields, overflow}))
        else $error("field payload changed while stalled");

    // an empty-result marker closes the string with zero offsets
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && no_fields |-> last_field && field_start == '0 && field_end == '0)
        else $error("no_fields result malformed");

    // fields never run backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !no_fields |-> field_start <= field_end)
        else $error("field start beyond field end");

endmodule

bind fixed_delimiter_field_splitter fdfs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (field_stream.valid),
    .ready       (field_stream.ready),
    .field_start (field_stream.field_start),
    .field_end   (field_stream.field_end),
    .last_field  (field_stream.last_field),
    .no_fields   (field_stream.no_fields),
    .overflow    (field_stream.overflow)
);
